// ===== rtl/core/bsc_pkg.sv =====
// Shared types, constants and match functions of the banner service classifier.
package bsc_pkg;

   localparam int NumCells = 6;
   localparam int NumPat   = 13;
   localparam int SeqLen   = NumCells + 1;
   localparam int PatBits  = 8 * SeqLen;

   // Index of each sticky pattern flag.
   localparam int PatHttpSlash = 0;
   localparam int PatServer    = 1;
   localparam int PatGet       = 2;
   localparam int PatHead      = 3;
   localparam int PatSsh       = 4;
   localparam int Pat220       = 5;
   localparam int PatSmtp      = 6;
   localparam int PatFtp       = 7;
   localparam int Pat220Sp     = 8;
   localparam int PatPop3      = 9;
   localparam int PatPlusOk    = 10;
   localparam int PatSmtpAny   = 11;
   localparam int PatHttpAny   = 12;

   typedef enum logic [2:0] {
      SVC_UNKNOWN = 3'd0,
      SVC_HTTP    = 3'd1,
      SVC_SSH     = 3'd2,
      SVC_SMTP    = 3'd3,
      SVC_FTP     = 3'd4,
      SVC_POP3    = 3'd5
   } svc_type;

   typedef logic [SeqLen-1:0][7:0] seq_type;
   typedef logic [NumPat-1:0]      seen_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

   // The last character of each pattern sits in the lowest byte.
   localparam logic [PatBits-1:0] PatText [NumPat] = '{
      PatBits'("HTTP/"),
      PatBits'("Server:"),
      PatBits'("GET "),
      PatBits'("HEAD "),
      PatBits'("SSH-"),
      PatBits'("220"),
      PatBits'("SMTP"),
      PatBits'("FTP"),
      PatBits'("220 "),
      PatBits'("POP3"),
      PatBits'("+OK"),
      PatBits'("smtp"),
      PatBits'("http")
   };

   localparam logic [2:0] PatLen [NumPat] = '{
      3'd5, 3'd7, 3'd4, 3'd5, 3'd4, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd3, 3'd4, 3'd4
   };

   localparam seen_type PatFold = seen_type'((1 << PatSmtpAny) | (1 << PatHttpAny));

   function automatic logic [7:0] fold_case(logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   // Sequence byte 0 is the current byte, byte k is the window entry k-1.
   function automatic logic pat_hit(seq_type seq, logic [PatBits-1:0] pat,
                                    logic [2:0] len, logic fold);
      logic ok;
      logic [7:0] a;
      logic [7:0] b;
      ok = 1'b1;
      for (int j = 0; j < SeqLen; j++) begin
         a = fold ? fold_case(seq[j]) : seq[j];
         b = pat[8*j +: 8];
         if (j < int'(len) && a != b) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic svc_type pick_code(seen_type s);
      if (s[PatHttpSlash] || s[PatServer] || s[PatGet] || s[PatHead]) begin
         return SVC_HTTP;
      end
      if (s[PatSsh]) begin
         return SVC_SSH;
      end
      if (s[Pat220] && s[PatSmtp]) begin
         return SVC_SMTP;
      end
      if (s[PatFtp] || s[Pat220Sp]) begin
         return SVC_FTP;
      end
      if (s[PatPop3] || s[PatPlusOk]) begin
         return SVC_POP3;
      end
      if (s[PatSmtpAny]) begin
         return SVC_SMTP;
      end
      if (s[PatHttpAny]) begin
         return SVC_HTTP;
      end
      return SVC_UNKNOWN;
   endfunction

endpackage

// ===== rtl/core/bsc_cell.sv =====
// One byte cell of the banner window chain.
module bsc_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  bsc_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]             prev_byte,
   output logic [7:0]             byte_out
);
   import bsc_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // Clearing between banners wins over a shift.
   always_comb begin
      byte_in = byte_ff;
      if (ctrl.clear) begin
         byte_in = 8'd0;
      end else if (ctrl.shift) begin
         byte_in = prev_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

endmodule

// ===== rtl/core/banner_service_classifier_core.sv =====
// Top level of the banner service classifier: cell chain, pattern flags and result stage.
// Each banner's code is registered when its last byte is accepted.
// Throughput: one byte per cycle while the skid is empty; the six-cell window shifts and
// all patterns compare in the same cycle against the window and the incoming byte.
// A two-entry output stage (register plus skid) keeps input flowing while a result waits.
// Synchronous reset clears the window, the pattern flags, the end flag and the output stage.
module banner_service_classifier_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] banner_byte
   input  logic       req_tlast,   // last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [2:0] service_code, [7:3] zero
);
   import bsc_pkg::*;

   logic [NumCells-1:0][7:0] win;
   cell_ctrl_type            cell_ctrl;
   seq_type                  seq;
   seen_type                 hits;
   seen_type                 seen_ff;
   seen_type                 seen_in;
   logic                     ended_ff;
   logic                     ended_in;
   logic                     req_fire;
   logic                     active;
   logic                     produce;
   svc_type                  code;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   svc_type                  rsp_code_ff;
   svc_type                  rsp_code_in;
   logic                     skid_valid_ff;
   logic                     skid_valid_in;
   svc_type                  skid_code_ff;
   svc_type                  skid_code_in;
   logic                     out_free;

   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign active     = req_fire && !ended_ff && (req_tdata != 8'd0);
   assign produce    = req_fire && req_tlast;

   assign cell_ctrl.clear = produce;
   assign cell_ctrl.shift = active;

   for (genvar i = 0; i < NumCells; i++) begin : g_cell
      if (i == 0) begin : g_head
         bsc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (cell_ctrl),
            .prev_byte (req_tdata),
            .byte_out  (win[i])
         );
      end else begin : g_body
         bsc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (cell_ctrl),
            .prev_byte (win[i-1]),
            .byte_out  (win[i])
         );
      end
   end

   always_comb begin
      seq[0] = req_tdata;
      for (int k = 1; k < SeqLen; k++) begin
         seq[k] = win[k-1];
      end
      for (int p = 0; p < NumPat; p++) begin
         hits[p] = pat_hit(seq, PatText[p], PatLen[p], PatFold[p]);
      end
   end

   always_comb begin
      seen_in  = seen_ff;
      ended_in = ended_ff;
      if (req_fire && !ended_ff) begin
         if (req_tdata == 8'd0) begin
            ended_in = 1'b1;
         end else begin
            seen_in = seen_ff | hits;
         end
      end
      code = pick_code(seen_in);
      if (produce) begin
         seen_in  = '0;
         ended_in = 1'b0;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_code_in   = rsp_code_ff;
      skid_valid_in = skid_valid_ff;
      skid_code_in  = skid_code_ff;
      if (out_free) begin
         rsp_valid_in  = skid_valid_ff || produce;
         rsp_code_in   = skid_valid_ff ? skid_code_ff : code;
         skid_valid_in = 1'b0;
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_code_in  = code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff       <= '0;
         ended_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         seen_ff       <= seen_in;
         ended_ff      <= ended_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_code_ff  <= rsp_code_in;
      skid_code_ff <= skid_code_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_code_ff};

`ifndef SYNTHESIS
   // The skid entry only ever fills behind a waiting output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   // A banner's last byte leaves no flags, no end mark and an empty window behind.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> (seen_ff == '0 && !ended_ff && win == '0))
      else $error("state not cleared after the last byte of a banner");

   // A zero byte that is not last ends the text.
   a_zero_ends_text: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_tlast && req_tdata == 8'd0) |=> ended_ff)
      else $error("zero byte did not end the text");

   // Nothing shifts into the window once the text has ended.
   a_window_frozen: assert property (@(posedge clock) disable iff (reset)
      (ended_ff && !(req_fire && req_tlast)) |=> $stable(win))
      else $error("window moved after the end of the text");

   // Codes above pop3 mean nothing.
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_code_ff == SVC_UNKNOWN || rsp_code_ff == SVC_HTTP ||
                        rsp_code_ff == SVC_SSH || rsp_code_ff == SVC_SMTP ||
                        rsp_code_ff == SVC_FTP || rsp_code_ff == SVC_POP3))
      else $error("service code out of range");
`endif

endmodule
